// File: rtl/core/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: rtl/core/jchd_pkg.sv
package jchd_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_CODE_LENGTH_DEF = 16;
    localparam int SYMBOL_SLOTS_DEF    = 162;

    // Fixed widths of the datapath.
    localparam int BYTE_W  = 8;
    localparam int CODE_W  = 16;
    localparam int FIRST_W = 17;
    localparam int SLOT_W  = 9;

    // Saturation value of the first code of a length.
    localparam logic [FIRST_W-1:0] FIRST_MAX = '1;

    // Operation codes of an input beat.
    localparam logic [1:0] OP_LOAD_OFFSET = 2'd0;
    localparam logic [1:0] OP_LOAD_SYMBOL = 2'd1;
    localparam logic [1:0] OP_DECODE      = 2'd2;

    typedef struct packed {
        logic [1:0]        operation;
        logic [BYTE_W-1:0] table_index;
        logic [BYTE_W-1:0] table_value;
        logic              code_bit;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] symbol;
        logic              invalid_code;
    } t_out_item;

    // Write request to one of the tables.
    typedef struct packed {
        logic              en;
        logic [BYTE_W-1:0] index;
        logic [BYTE_W-1:0] value;
    } t_tbl_wr;

endpackage

// File: rtl/core/jpeg_canonical_huffman_decoder.sv
// Canonical Huffman decoder for JPEG entropy-coded data, one bit per input beat.
// Input channel (i_in_valid / o_in_ready, i_in_item): a beat either loads an
// entry of the cumulative offset table, loads an entry of the symbol table, or
// carries one coded bit, most significant first. Loads give no result.
// Output channel (o_out_valid / i_out_ready, o_out_item): one beat for every bit
// that completes a code (the symbol, or zero for a slot past the symbol table) and
// for every sixteenth bit without a match (invalid_code set, symbol zero).
// Throughput: one input beat per cycle while the receiver does not stall. The
// offsets for the next code length are read from a two-port offset memory in the
// same cycle as the current bit is compared, and the matched slot is read from the
// symbol memory on the accept edge. A result is registered in the symbol read
// stage, then moves to the output register when the output is not stalled.
// Reset (synchronous, active low) clears the partial code and the pipeline; both
// tables are undefined until loaded, and no clearing pass is run.
// When the receiver stalls, one finished result waits in the output register and
// one more in the symbol read stage; input is taken while the latter is free.
module jpeg_canonical_huffman_decoder
    import jchd_pkg::*;
#(
    parameter int MAX_CODE_LENGTH = MAX_CODE_LENGTH_DEF,
    parameter int SYMBOL_SLOTS    = SYMBOL_SLOTS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    localparam int OFF_AW = $clog2(MAX_CODE_LENGTH + 1);

    logic [OFF_AW-1:0]  r_level;
    logic [OFF_AW-1:0]  n_level;
    logic [CODE_W-1:0]  r_partial;
    logic [CODE_W-1:0]  n_partial;
    logic [FIRST_W-1:0] r_first;
    logic [FIRST_W-1:0] n_first;
    logic               r_a_valid;
    logic               r_a_err;
    logic               r_a_zero;
    logic               r_o_valid;
    t_out_item          r_o_item;

    logic               accept;
    logic               dec;
    logic               out_stall;
    logic               a_free;
    t_tbl_wr            wr_off;
    t_tbl_wr            wr_sym;
    logic [OFF_AW-1:0]  rd_level;
    logic [BYTE_W-1:0]  lo;
    logic [BYTE_W-1:0]  hi;
    logic [BYTE_W-1:0]  count;
    logic [CODE_W-1:0]  code;
    logic [FIRST_W-1:0] diff;
    logic               hit;
    logic [SLOT_W-1:0]  slot;
    logic               slot_ok;
    logic [OFF_AW-1:0]  level_inc;
    logic               exhausted;
    logic [FIRST_W:0]   first_sum;
    logic [FIRST_W+1:0] first_shl;
    logic [BYTE_W-1:0]  sym_rd;

    // Handshake: the read stage may take a new result whenever it is empty or can move on.
    assign out_stall  = r_o_valid && !i_out_ready;
    assign a_free     = !r_a_valid || !out_stall;
    assign o_in_ready = a_free;
    assign accept     = i_in_valid && o_in_ready;
    assign dec        = accept && (i_in_item.operation == OP_DECODE);

    // Table write requests.
    assign wr_off = '{en:    accept && (i_in_item.operation == OP_LOAD_OFFSET),
                      index: i_in_item.table_index,
                      value: i_in_item.table_value};
    assign wr_sym = '{en:    accept && (i_in_item.operation == OP_LOAD_SYMBOL),
                      index: i_in_item.table_index,
                      value: i_in_item.table_value};

    // Range check of the extended code against the current length.
    always_comb begin
        count     = (hi > lo) ? (hi - lo) : '0;
        code      = {r_partial[CODE_W-2:0], i_in_item.code_bit};
        diff      = {1'b0, code} - r_first;
        hit       = ({1'b0, code} >= r_first) && (diff < FIRST_W'(count));
        slot      = SLOT_W'(lo) + SLOT_W'(diff[BYTE_W-1:0]);
        slot_ok   = slot < SLOT_W'(SYMBOL_SLOTS);
        level_inc = r_level + OFF_AW'(1);
        exhausted = level_inc == OFF_AW'(MAX_CODE_LENGTH);
        first_sum = {1'b0, r_first} + (FIRST_W + 1)'(count);
        first_shl = {first_sum, 1'b0};
    end

    // Next code state: restart on a match or after the longest length.
    always_comb begin
        n_level   = r_level;
        n_partial = r_partial;
        n_first   = r_first;
        if (dec) begin
            if (hit || exhausted) begin
                n_level   = '0;
                n_partial = '0;
                n_first   = '0;
            end else begin
                n_level   = level_inc;
                n_partial = code;
                n_first   = (first_shl > (FIRST_W + 2)'(FIRST_MAX)) ?
                            FIRST_MAX : first_shl[FIRST_W-1:0];
            end
        end
    end

    // The offsets of the next length are fetched on the same edge.
    assign rd_level = i_rst_n ? n_level : '0;

    jchd_offset_ram #(
        .MAX_CODE_LENGTH(MAX_CODE_LENGTH)
    ) u_offset_ram (
        .i_clk      (i_clk),
        .i_wr       (wr_off),
        .i_rd_level (rd_level),
        .o_lo       (lo),
        .o_hi       (hi)
    );

    jchd_symbol_ram #(
        .SYMBOL_SLOTS(SYMBOL_SLOTS)
    ) u_symbol_ram (
        .i_clk     (i_clk),
        .i_wr      (wr_sym),
        .i_rd_en   (dec && hit && slot_ok),
        .i_rd_slot (slot),
        .o_symbol  (sym_rd)
    );

    // Code state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level   <= '0;
            r_partial <= '0;
            r_first   <= '0;
        end else begin
            r_level   <= n_level;
            r_partial <= n_partial;
            r_first   <= n_first;
        end
    end

    // Symbol read stage: flags travel beside the memory read data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_free) begin
            r_a_valid <= dec && (hit || exhausted);
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_free) begin
            r_a_err  <= !hit;
            r_a_zero <= hit && !slot_ok;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (!out_stall) begin
            r_o_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_a_valid && !out_stall) begin
            r_o_item.symbol       <= (r_a_err || r_a_zero) ? '0 : sym_rd;
            r_o_item.invalid_code <= r_a_err;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_item  = r_o_item;

endmodule

// File: rtl/core/jchd_offset_ram.sv
module jchd_offset_ram
    import jchd_pkg::*;
#(
    parameter int MAX_CODE_LENGTH = MAX_CODE_LENGTH_DEF,
    localparam int ENTRIES = MAX_CODE_LENGTH + 1,
    localparam int OFF_AW  = $clog2(ENTRIES)
) (
    input  logic              i_clk,
    input  t_tbl_wr           i_wr,
    input  logic [OFF_AW-1:0] i_rd_level,
    output logic [BYTE_W-1:0] o_lo,
    output logic [BYTE_W-1:0] o_hi
);

    logic [BYTE_W-1:0] mem [ENTRIES];
    logic [BYTE_W-1:0] r_lo;
    logic [BYTE_W-1:0] r_hi;
    logic              wr_ok;
    logic [OFF_AW-1:0] wr_addr;
    logic [OFF_AW-1:0] addr_lo;
    logic [OFF_AW-1:0] addr_hi;

    // Writes beyond the table are dropped.
    assign wr_ok   = i_wr.en && (i_wr.index < BYTE_W'(ENTRIES));
    assign wr_addr = i_wr.index[OFF_AW-1:0];
    assign addr_lo = i_rd_level;
    assign addr_hi = i_rd_level + OFF_AW'(1);

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            mem[wr_addr] <= i_wr.value;
        end
    end

    // Two read ports; a write to the same entry in the same cycle is passed through.
    always_ff @(posedge i_clk) begin
        if (wr_ok && wr_addr == addr_lo) begin
            r_lo <= i_wr.value;
        end else begin
            r_lo <= mem[addr_lo];
        end
        if (wr_ok && wr_addr == addr_hi) begin
            r_hi <= i_wr.value;
        end else begin
            r_hi <= mem[addr_hi];
        end
    end

    assign o_lo = r_lo;
    assign o_hi = r_hi;

endmodule

// File: rtl/core/jchd_symbol_ram.sv
module jchd_symbol_ram
    import jchd_pkg::*;
#(
    parameter int SYMBOL_SLOTS = SYMBOL_SLOTS_DEF,
    localparam int SYM_AW = (SYMBOL_SLOTS > 1) ? $clog2(SYMBOL_SLOTS) : 1
) (
    input  logic              i_clk,
    input  t_tbl_wr           i_wr,
    input  logic              i_rd_en,
    input  logic [SLOT_W-1:0] i_rd_slot,
    output logic [BYTE_W-1:0] o_symbol
);

    logic [BYTE_W-1:0] mem [SYMBOL_SLOTS];
    logic [BYTE_W-1:0] r_rd;
    logic              wr_ok;

    // Writes beyond the table are dropped.
    assign wr_ok = i_wr.en && (SLOT_W'(i_wr.index) < SLOT_W'(SYMBOL_SLOTS));

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            mem[i_wr.index[SYM_AW-1:0]] <= i_wr.value;
        end
    end

    // The read data is held until the next enabled read.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd <= mem[i_rd_slot[SYM_AW-1:0]];
        end
    end

    assign o_symbol = r_rd;

endmodule

// File: rtl/core/jchd_checker.sv
`include "assert_macros.svh"

module jchd_checker
    import jchd_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_item  i_in_item,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_item
);

    // A stalled input beat stays offered and unchanged.
    `ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, i_in_valid && !o_in_ready,
                 i_in_valid && $stable(i_in_item))

    // A stalled result beat stays offered and unchanged.
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)
    `ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(o_out_item))

    // An error beat never carries a symbol.
    `ASSERT_SAME(a_err_zero, i_clk, i_rst_n, o_out_valid && o_out_item.invalid_code,
                 o_out_item.symbol == '0)

    // With the output empty nothing can hold the input back.
    `ASSERT_SAME(a_ready_empty, i_clk, i_rst_n, !o_out_valid, o_in_ready)

endmodule

bind jpeg_canonical_huffman_decoder jchd_checker u_jchd_checker (.*);

// File: sim/tb.sv
module tb;
    import jchd_pkg::*;

    localparam int          N_LENGTHS  = MAX_CODE_LENGTH_DEF;
    localparam int          N_OFFSETS  = MAX_CODE_LENGTH_DEF + 1;
    localparam int          N_SLOTS    = SYMBOL_SLOTS_DEF;
    localparam logic [1:0]  OP_UNUSED  = 2'd3;
    localparam int          BEAT_COUNT = 1800;
    localparam int          HOLD_LEN   = 120;
    localparam int          IDLE_LIMIT = 2000;
    localparam int          MAX_REPORTS = 10;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_ready;
    t_out_item out_item;

    // Decoder state as the testbench expects it to be.
    int unsigned dec_partial;
    int unsigned dec_len;
    int unsigned dec_first;
    logic [7:0]  dec_offsets [0:N_OFFSETS-1];
    logic [7:0]  dec_symbols [0:N_SLOTS-1];

    // Offset table being prepared for the next load.
    logic [7:0]  staged_offsets [0:N_OFFSETS-1];

    t_out_item   pending_symbols [$];
    int          beats_sent;
    int          mismatches;
    int          idle_cycles;
    bit          hold_request;
    bit          no_gaps;

    jpeg_canonical_huffman_decoder dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item)
    );

    // Clock with a period of two time units.
    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Work out the result, if any, of one accepted input beat.
    task automatic predict_decoder(input t_in_item beat);
        int unsigned lvl;
        int unsigned code;
        int unsigned lo;
        int unsigned hi;
        int unsigned cnt;
        int unsigned slot;
        int unsigned nxt;
        t_out_item   res;
        case (beat.operation)
            OP_LOAD_OFFSET: begin
                if (beat.table_index < N_OFFSETS)
                    dec_offsets[beat.table_index] = beat.table_value;
            end
            OP_LOAD_SYMBOL: begin
                if (beat.table_index < N_SLOTS)
                    dec_symbols[beat.table_index] = beat.table_value;
            end
            OP_DECODE: begin
                lvl  = (dec_len >= N_LENGTHS) ? N_LENGTHS - 1 : dec_len;
                code = ((dec_partial << 1) | beat.code_bit) & 32'hFFFF;
                lo   = dec_offsets[lvl];
                hi   = dec_offsets[lvl+1];
                cnt  = (hi > lo) ? hi - lo : 0;
                if (code >= dec_first && code - dec_first < cnt) begin
                    slot = lo + code - dec_first;
                    res.symbol = '0;
                    if (slot < N_SLOTS)
                        res.symbol = dec_symbols[slot];
                    res.invalid_code = 1'b0;
                    pending_symbols.push_back(res);
                    dec_partial = 0;
                    dec_len     = 0;
                    dec_first   = 0;
                end else begin
                    nxt = (dec_first + cnt) << 1;
                    if (nxt > 32'h1FFFF)
                        nxt = 32'h1FFFF;
                    dec_first   = nxt;
                    dec_partial = code;
                    dec_len     = lvl + 1;
                    if (dec_len >= N_LENGTHS) begin
                        res.symbol       = '0;
                        res.invalid_code = 1'b1;
                        pending_symbols.push_back(res);
                        dec_partial = 0;
                        dec_len     = 0;
                        dec_first   = 0;
                    end
                end
            end
            default: ;
        endcase
    endtask

    function automatic t_in_item make_beat(input logic [1:0] op, input logic [7:0] idx,
                                           input logic [7:0] val, input logic bitv);
        t_in_item beat;
        beat.operation   = op;
        beat.table_index = idx;
        beat.table_value = val;
        beat.code_bit    = bitv;
        return beat;
    endfunction

    // Offer one beat, after a random gap, and hold it until it is taken.
    task automatic send_beat(input t_in_item beat);
        int gap;
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60)
            gap = 0;
        else if (r < 92)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 40);
        if (gap > 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_item  <= beat;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_decoder(beat);
        beats_sent++;
    endtask

    // A decode beat with random filler in the fields that it does not use.
    task automatic send_bit(input logic bitv);
        send_beat(make_beat(OP_DECODE, 8'($urandom), 8'($urandom), bitv));
    endtask

    task automatic send_random_bits(input int n);
        repeat (n) send_bit(1'($urandom));
    endtask

    // A random load of either table, with any index at all.
    task automatic send_random_load();
        send_beat(make_beat($urandom_range(0, 1) ? OP_LOAD_SYMBOL : OP_LOAD_OFFSET,
                            8'($urandom), 8'($urandom), 1'($urandom)));
    endtask

    task automatic load_staged_offsets();
        for (int i = 0; i < N_OFFSETS; i++)
            send_beat(make_beat(OP_LOAD_OFFSET, 8'(i), staged_offsets[i], 1'($urandom)));
    endtask

    // Bring the decoder back to the start of a code with random bits.
    task automatic finish_partial_code();
        while (dec_len != 0) send_bit(1'($urandom));
    endtask

    // Build a random offset table that does not oversubscribe the code space.
    task automatic make_canonical_table();
        int unsigned avail;
        int unsigned total;
        int unsigned cap;
        int unsigned cnt;
        avail = 2;
        total = 0;
        staged_offsets[0] = 8'd0;
        for (int len = 1; len <= N_LENGTHS; len++) begin
            cap = (avail < N_SLOTS - total) ? avail : N_SLOTS - total;
            if (cap > 12)
                cap = 12;
            cnt = (cap == 0) ? 0 : $urandom_range(0, cap);
            if (len == N_LENGTHS && total == 0)
                cnt = 1;
            total += cnt;
            staged_offsets[len] = 8'(total);
            avail = (avail - cnt) * 2;
            if (avail > 1024)
                avail = 1024;
        end
    endtask

    // Send the code of one symbol slot under the current tables, most
    // significant bit first, now and then with a load slipped in between bits.
    task automatic send_symbol_code(input int unsigned slot, input int load_pct,
                                    output bit found);
        int unsigned first;
        int unsigned lo;
        int unsigned hi;
        int unsigned cnt;
        int unsigned code;
        int          len;
        found = 1'b0;
        first = 0;
        len   = 0;
        code  = 0;
        finish_partial_code();
        for (int lvl = 0; lvl < N_LENGTHS && !found; lvl++) begin
            lo  = dec_offsets[lvl];
            hi  = dec_offsets[lvl+1];
            cnt = (hi > lo) ? hi - lo : 0;
            if (slot >= lo && slot < lo + cnt) begin
                found = 1'b1;
                code  = first + slot - lo;
                len   = lvl + 1;
            end
            first = (first + cnt) << 1;
            if (first > 32'h1FFFF)
                first = 32'h1FFFF;
        end
        for (int k = len - 1; k >= 0; k--) begin
            if ($urandom_range(0, 99) < load_pct)
                send_random_load();
            send_bit(code[k]);
        end
    endtask

    // Fill both tables: a canonical offset table and every symbol slot.
    task automatic test_table_load();
        make_canonical_table();
        load_staged_offsets();
        for (int i = 0; i < N_SLOTS; i++) begin
            send_beat(make_beat(OP_LOAD_SYMBOL, 8'(i),
                                (i == 0) ? 8'h00 : (i == N_SLOTS - 1) ? 8'hFF : 8'($urandom),
                                1'($urandom)));
        end
    endtask

    // Loads beyond either table and the unused operation must change nothing,
    // and must not disturb a code in progress.
    task automatic test_ignored_beats();
        bit found;
        send_bit(1'b0);
        send_beat(make_beat(OP_LOAD_OFFSET, 8'(N_OFFSETS), 8'hFF, 1'b1));
        send_beat(make_beat(OP_LOAD_OFFSET, 8'hFF, 8'h00, 1'b0));
        send_beat(make_beat(OP_LOAD_SYMBOL, 8'(N_SLOTS), 8'hFF, 1'b1));
        send_beat(make_beat(OP_LOAD_SYMBOL, 8'hFF, 8'hFF, 1'b0));
        send_beat(make_beat(OP_UNUSED, 8'hFF, 8'hFF, 1'b1));
        send_beat(make_beat(OP_UNUSED, 8'h00, 8'h00, 1'b0));
        send_bit(1'b1);
        send_symbol_code(N_SLOTS - 1, 0, found);
        send_symbol_code(0, 0, found);
    endtask

    // Offsets that fall from one length to the next leave no codes at all,
    // so sixteen bits end in an invalid code.
    task automatic test_invalid_code();
        for (int i = 0; i < N_OFFSETS; i++)
            staged_offsets[i] = 8'(255 - 15 * i);
        load_staged_offsets();
        finish_partial_code();
        send_random_bits(N_LENGTHS);
    endtask

    // Codes whose slot lies past the symbol table give symbol zero, and an
    // oversubscribed length matches on the first bit.
    task automatic test_slot_overflow();
        staged_offsets[0] = 8'd170;
        for (int i = 1; i < N_OFFSETS; i++)
            staged_offsets[i] = 8'd172;
        load_staged_offsets();
        finish_partial_code();
        send_bit(1'b0);
        send_bit(1'b1);
        staged_offsets[0] = 8'd0;
        for (int i = 1; i < N_OFFSETS; i++)
            staged_offsets[i] = 8'hFF;
        load_staged_offsets();
        send_bit(1'b1);
        send_bit(1'b0);
    endtask

    // The receiver holds off for a long stretch while codes of one bit keep
    // arriving, so the block fills and has to stall its input.
    task automatic test_backpressure();
        staged_offsets[0] = 8'd0;
        for (int i = 1; i < N_OFFSETS; i++)
            staged_offsets[i] = 8'd2;
        load_staged_offsets();
        finish_partial_code();
        no_gaps      = 1'b1;
        hold_request = 1'b1;
        send_random_bits(40);
        no_gaps = 1'b0;
        while (hold_request) @(posedge clk);
    endtask

    // Random tables, mostly canonical, decoded with mostly well-formed codes
    // and a share of stray bits, loads and unused beats.
    task automatic test_random_tables();
        bit found;
        int r;
        while (beats_sent < BEAT_COUNT) begin
            if ($urandom_range(0, 3) != 0) begin
                make_canonical_table();
            end else begin
                for (int i = 0; i < N_OFFSETS; i++)
                    staged_offsets[i] = 8'($urandom);
            end
            load_staged_offsets();
            repeat ($urandom_range(0, 6)) send_random_load();
            no_gaps = ($urandom_range(0, 5) == 0);
            repeat ($urandom_range(15, 40)) begin
                r = $urandom_range(0, 99);
                if (r < 80) begin
                    found = 1'b0;
                    for (int t = 0; t < 8 && !found; t++)
                        send_symbol_code($urandom_range(0, 175), 3, found);
                end else if (r < 92) begin
                    send_random_bits($urandom_range(1, 6));
                end else if (r < 96) begin
                    send_beat(make_beat(OP_UNUSED, 8'($urandom), 8'($urandom), 1'($urandom)));
                end else begin
                    send_random_load();
                end
            end
            no_gaps = 1'b0;
        end
    endtask

    // Receiver: random ready with short and long stalls, steady ready when no gaps
    // are asked for, or one long hold when asked for.
    initial begin
        int r;
        int n;
        out_ready = 1'b0;
        forever begin
            if (hold_request) begin
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (HOLD_LEN - 1) @(negedge clk);
                hold_request = 1'b0;
            end else if (no_gaps) begin
                @(negedge clk);
                out_ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                n = (r < 65) ? $urandom_range(1, 12) :
                    (r < 93) ? $urandom_range(1, 3) : $urandom_range(10, 30);
                @(negedge clk);
                out_ready <= (r < 65);
                repeat (n - 1) @(negedge clk);
            end
        end
    end

    task automatic note_mismatch(input string what, input t_out_item want,
                                 input t_out_item got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch (%s): expected symbol %02h invalid %0b, got symbol %02h invalid %0b",
                     what, want.symbol, want.invalid_code, got.symbol, got.invalid_code);
    endtask

    // Compare each result beat with the oldest expectation.
    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_symbols.size() == 0) begin
                want = '0;
                note_mismatch("no result expected", want, out_item);
            end else begin
                want = pending_symbols.pop_front();
                if (out_item.symbol !== want.symbol ||
                    out_item.invalid_code !== want.invalid_code)
                    note_mismatch("wrong result", want, out_item);
            end
        end
    end

    // Watchdog on cycles in which neither side moves a beat.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL jpeg_canonical_huffman_decoder");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Reset, the tests in turn, then drain and report.
    initial begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_item      = '0;
        dec_partial  = 0;
        dec_len      = 0;
        dec_first    = 0;
        beats_sent   = 0;
        mismatches   = 0;
        idle_cycles  = 0;
        hold_request = 1'b0;
        no_gaps      = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_table_load();
        test_ignored_beats();
        test_invalid_code();
        test_slot_overflow();
        test_backpressure();
        test_random_tables();

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_symbols.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0) begin
            $display("PASS jpeg_canonical_huffman_decoder");
        end else begin
            $display("FAIL jpeg_canonical_huffman_decoder");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/jchd_pkg.sv
rtl/core/jchd_offset_ram.sv
rtl/core/jchd_symbol_ram.sv
rtl/core/jpeg_canonical_huffman_decoder.sv
rtl/core/jchd_checker.sv
sim/tb.sv
